// ===== rtl/core/log_bucket_quantile_sketch_defines.svh =====
// assertion macros for the log bucket quantile sketch checker
// no dependencies; included by the checker file only
`ifndef LOG_BUCKET_QUANTILE_SKETCH_DEFINES_SVH
`define LOG_BUCKET_QUANTILE_SKETCH_DEFINES_SVH

// same-cycle implication, disabled in reset
`define LBQS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define LBQS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/lbqs_pkg.sv =====
// shared types, constants and helpers of the log bucket quantile sketch
// no dependencies; imported by every module of the block but lbqs_ram
`timescale 1ns / 1ps

package lbqs_pkg;

    localparam int NUM_BUCKETS   = 2048;
    localparam int HALF_BUCKETS  = NUM_BUCKETS / 2;
    localparam int SLOT_W        = $clog2(NUM_BUCKETS);
    localparam int LOG_FRAC_BITS = 16;
    localparam int ITER_W        = $clog2(LOG_FRAC_BITS + 1);
    localparam int L_W           = LOG_FRAC_BITS + 6;
    localparam int P_W           = L_W + 33;
    localparam int IDX_SHIFT     = LOG_FRAC_BITS + 16;

    localparam int VAL_W     = 32;
    localparam int MULT_W    = 32;
    localparam int Q_W       = 17;
    localparam int CNT_W     = 48;
    localparam int SUM_W     = 63;
    localparam int PROD_W    = 64;
    localparam int RANK_W    = CNT_W + 1;
    localparam int CUM_W     = CNT_W + SLOT_W;
    localparam int IDX_OUT_W = 11;

    localparam logic [Q_W-1:0]    Q_ONE          = Q_W'(65536);
    localparam logic [CNT_W-1:0]  CNT_MAX        = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX        = {SUM_W{1'b1}};
    localparam logic [MULT_W-1:0] MULT_RESET     = MULT_W'(2271400);

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ZERO  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_ZERO  = 3'd1,
        OP_QUERY = 3'd2,
        OP_CLEAR = 3'd3,
        OP_NOP   = 3'd4
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] weight;
        logic [Q_W-1:0]   qfrac;
    } item_t;

    // queue handshake between front and back
    typedef struct packed {
        logic  valid;
        item_t item;
    } qout_t;

    typedef struct packed {
        status_t              status;
        logic [IDX_OUT_W-1:0] bucket_index;
        logic [CNT_W-1:0]     total_count;
        logic [SUM_W-1:0]     value_sum;
        logic [VAL_W-1:0]     min_seen;
        logic [VAL_W-1:0]     max_seen;
    } result_t;

    function automatic logic [IDX_OUT_W-1:0] slot_to_index(input logic [SLOT_W-1:0] slot);
        int d;
        d = int'(slot) - HALF_BUCKETS;
        return IDX_OUT_W'(d);
    endfunction

endpackage

// ===== rtl/core/lbqs_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lbqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/lbqs_front.sv =====
// front end: accepts requests, decodes them and queues them for the engine
// depends on lbqs_pkg
`timescale 1ns / 1ps

module lbqs_front
    import lbqs_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // sample_value, weight, quantile_fraction, pad
    input  logic [1:0]  s_tuser,   // func
    input  logic        init_busy,
    input  logic        q_pop,
    output qout_t       q_out
);

    item_t      slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    item_t      dec;
    logic       push;

    always_comb begin
        dec.value  = s_tdata[31:0];
        dec.weight = s_tdata[63:32];
        dec.qfrac  = (s_tdata[80:64] > Q_ONE) ? Q_ONE : s_tdata[80:64];
        case (s_tuser)
            FUNC_ADD:   dec.op = (s_tdata[31:0] == '0) ? OP_ZERO : OP_ADD;
            FUNC_QUERY: dec.op = OP_QUERY;
            FUNC_CLEAR: dec.op = OP_CLEAR;
            default:    dec.op = OP_NOP;
        endcase
    end

    assign s_tready    = (count_reg != 2'd2) && !init_busy;
    assign push        = s_tvalid && s_tready;
    assign q_out.valid = (count_reg != 2'd0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

// ===== rtl/core/lbqs_back.sv =====
// back end: log index, bucket update, quantile walk and clearing pass
// depends on lbqs_pkg and lbqs_ram
`timescale 1ns / 1ps

module lbqs_back
    import lbqs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [MULT_W-1:0] index_multiplier,
    input  qout_t             q_in,
    output logic              q_pop,
    output logic              init_busy,
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CLR   = 11'b000_0000_0010,
        S_NORM  = 11'b000_0000_0100,
        S_LOG   = 11'b000_0000_1000,
        S_MUL   = 11'b000_0001_0000,
        S_IDX   = 11'b000_0010_0000,
        S_RD    = 11'b000_0100_0000,
        S_UPD   = 11'b000_1000_0000,
        S_QMUL  = 11'b001_0000_0000,
        S_QWALK = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    localparam logic signed [P_W-1:0] ROUND_ADD = (P_W'(1) << IDX_SHIFT) - P_W'(1);
    localparam logic signed [P_W-1:0] IDX_MIN   = -(P_W'(HALF_BUCKETS));
    localparam logic signed [P_W-1:0] IDX_MAX   = P_W'(HALF_BUCKETS - 1);
    localparam logic [SLOT_W:0]       LAST_SLOT = (SLOT_W+1)'(NUM_BUCKETS - 1);

    state_t                   state_reg;
    logic                     init_reg;
    logic [SLOT_W:0]          clr_cnt_reg;
    item_t                    item_reg;
    logic [31:0]              x_reg;
    logic [4:0]               e_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [P_W-1:0]    p_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [SLOT_W-1:0]        slot_reg;
    logic [CNT_W-1:0]         total_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [VAL_W-1:0]         min_reg, max_reg;
    logic [RANK_W-1:0]        rank_reg;
    logic [CUM_W-1:0]         cum_reg;
    logic [SLOT_W:0]          issue_reg;
    logic                     rv_reg;
    logic [SLOT_W-1:0]        ridx_reg, last_reg;
    logic                     last_v_reg;
    status_t                  st_reg;
    logic [IDX_OUT_W-1:0]     bidx_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    // ram port signals
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    logic [CNT_W-1:0]  ram_wdata, ram_rdata;

    // datapath terms
    logic [4:0]             e_c;
    logic [63:0]            sq_c;
    logic [32:0]            t_c;
    logic [5:0]             eoff_c;
    logic signed [L_W-1:0]  l_c;
    logic signed [P_W-1:0]  pr_c, ish_c, sl_c;
    logic [SLOT_W-1:0]      slot_c;
    logic [CNT_W:0]         bsum_c, tsum_c;
    logic [SUM_W-1:0]       prodc_c;
    logic [SUM_W:0]         ssum_c;
    logic [Q_W+CNT_W-1:0]   qprod_c;
    logic [CUM_W-1:0]       cum_c;
    logic                   issue_v;
    logic                   load_out;

    lbqs_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BUCKETS)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        e_c = '0;
        for (int i = 0; i < 32; i++) begin
            if (item_reg.value[i]) begin
                e_c = 5'(i);
            end
        end
    end

    always_comb begin
        sq_c    = 64'(x_reg) * 64'(x_reg);
        t_c     = sq_c[63:31];
        eoff_c  = {1'b0, e_reg} - 6'd16;
        l_c     = {eoff_c, frac_reg};
        // ceiling of p / 2^shift for either sign
        pr_c    = p_reg + ROUND_ADD;
        ish_c   = pr_c >>> IDX_SHIFT;
        sl_c    = ish_c + P_W'(HALF_BUCKETS);
        if (ish_c < IDX_MIN) begin
            slot_c = '0;
        end else if (ish_c > IDX_MAX) begin
            slot_c = LAST_SLOT[SLOT_W-1:0];
        end else begin
            slot_c = sl_c[SLOT_W-1:0];
        end
        bsum_c  = {1'b0, ram_rdata} + (CNT_W+1)'(item_reg.weight);
        tsum_c  = {1'b0, total_reg} + (CNT_W+1)'(item_reg.weight);
        prodc_c = prod_reg[PROD_W-1] ? SUM_MAX : prod_reg[SUM_W-1:0];
        ssum_c  = {1'b0, sum_reg} + {1'b0, prodc_c};
        qprod_c = (Q_W+CNT_W)'(item_reg.qfrac) * (Q_W+CNT_W)'(total_reg);
        cum_c   = cum_reg + CUM_W'(ram_rdata);
        issue_v = !issue_reg[SLOT_W];
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = slot_reg;
        ram_wdata = bsum_c[CNT_W] ? CNT_MAX : bsum_c[CNT_W-1:0];
        ram_raddr = slot_reg;
        case (state_reg)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg[SLOT_W-1:0];
                ram_wdata = '0;
            end
            S_UPD: begin
                ram_we = 1'b1;
            end
            S_QWALK: begin
                ram_raddr = issue_reg[SLOT_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    assign q_pop     = (state_reg == S_IDLE) && q_in.valid;
    assign init_busy = init_reg;
    assign load_out  = (state_reg == S_DONE) && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg.status       <= st_reg;
            out_reg.bucket_index <= bidx_reg;
            out_reg.total_count  <= total_reg;
            out_reg.value_sum    <= sum_reg;
            out_reg.min_seen     <= min_reg;
            out_reg.max_seen     <= max_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLR;
            init_reg      <= 1'b1;
            clr_cnt_reg   <= '0;
            total_reg     <= '0;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (q_in.valid) begin
                        item_reg <= q_in.item;
                        st_reg   <= ST_OK;
                        bidx_reg <= '0;
                        case (q_in.item.op)
                            OP_ADD:   state_reg <= S_NORM;
                            OP_ZERO: begin
                                st_reg    <= ST_ZERO;
                                state_reg <= S_DONE;
                            end
                            OP_QUERY: state_reg <= S_QMUL;
                            OP_CLEAR: begin
                                clr_cnt_reg <= '0;
                                total_reg   <= '0;
                                sum_reg     <= '0;
                                min_reg     <= '0;
                                max_reg     <= '0;
                                state_reg   <= S_CLR;
                            end
                            default:  state_reg <= S_DONE;
                        endcase
                    end
                end
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == LAST_SLOT) begin
                        init_reg  <= 1'b0;
                        state_reg <= init_reg ? S_IDLE : S_DONE;
                    end
                end
                S_NORM: begin
                    e_reg     <= e_c;
                    x_reg     <= item_reg.value << (5'd31 - e_c);
                    frac_reg  <= '0;
                    iter_reg  <= '0;
                    prod_reg  <= 64'(item_reg.value) * 64'(item_reg.weight);
                    state_reg <= S_LOG;
                end
                S_LOG: begin
                    // one squaring per cycle yields one fraction bit
                    frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], t_c[32]};
                    x_reg    <= t_c[32] ? t_c[32:1] : t_c[31:0];
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(LOG_FRAC_BITS - 1)) begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    p_reg     <= l_c * $signed({1'b0, index_multiplier});
                    state_reg <= S_IDX;
                end
                S_IDX: begin
                    slot_reg  <= slot_c;
                    state_reg <= S_RD;
                end
                S_RD: begin
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    total_reg <= tsum_c[CNT_W] ? CNT_MAX : tsum_c[CNT_W-1:0];
                    sum_reg   <= ssum_c[SUM_W] ? SUM_MAX : ssum_c[SUM_W-1:0];
                    if (min_reg == '0 || item_reg.value < min_reg) begin
                        min_reg <= item_reg.value;
                    end
                    if (max_reg == '0 || item_reg.value > max_reg) begin
                        max_reg <= item_reg.value;
                    end
                    state_reg <= S_DONE;
                end
                S_QMUL: begin
                    if (total_reg == '0) begin
                        st_reg    <= ST_EMPTY;
                        state_reg <= S_DONE;
                    end else begin
                        rank_reg   <= qprod_c[Q_W+CNT_W-1:16];
                        cum_reg    <= '0;
                        issue_reg  <= '0;
                        rv_reg     <= 1'b0;
                        last_v_reg <= 1'b0;
                        state_reg  <= S_QWALK;
                    end
                end
                S_QWALK: begin
                    rv_reg   <= issue_v;
                    ridx_reg <= issue_reg[SLOT_W-1:0];
                    if (issue_v) begin
                        issue_reg <= issue_reg + 1'b1;
                    end
                    if (rv_reg && ram_rdata != '0) begin
                        cum_reg    <= cum_c;
                        last_reg   <= ridx_reg;
                        last_v_reg <= 1'b1;
                        if (cum_c > CUM_W'(rank_reg)) begin
                            bidx_reg  <= slot_to_index(ridx_reg);
                            state_reg <= S_DONE;
                        end
                    end else if (!issue_v && !rv_reg) begin
                        // walk ran out: highest nonempty bucket
                        if (last_v_reg) begin
                            bidx_reg <= slot_to_index(last_reg);
                        end else begin
                            st_reg <= ST_EMPTY;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/log_bucket_quantile_sketch.sv =====
// Log bucket quantile sketch (relative-error quantiles over log2 buckets).
// Requests enter on the s_ stream: tuser is the function (add, quantile, clear),
// tdata carries value, weight and quantile fraction. Every request gives one
// response on the m_ stream: tuser is the status, tdata the bucket index and
// the running total, sum, min and max after the request.
// An add runs normalize, then the log iterations, one squaring each, then
// multiply, index, bucket read and write. A quantile walks the 2048-entry
// bucket ram one read per cycle. A clear rewrites the ram.
// The engine works on one request at a time; a two-entry queue in front
// keeps accepting while it is busy.
// After reset the ram is cleared in one pass; s_tready stays low
// until it ends, configuration writes are taken throughout.
// A response that is not taken holds in the output register; the engine
// then waits with its next result, and the queue fills and stalls s_tready.
// index_multiplier lies at byte address 0 of the apb port.
// depends on lbqs_pkg, lbqs_front, lbqs_back
`timescale 1ns / 1ps

module log_bucket_quantile_sketch
    import lbqs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // sample_value, weight, quantile_fraction, zero pad
    input  logic [1:0]   s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [191:0] m_tdata,   // bucket_index, total_count, value_sum, min_seen,
                                    // max_seen, zero pad
    output logic [1:0]   m_tuser,   // status
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [MULT_W-1:0] mult_reg;
    logic              hit;
    qout_t             q_link;
    logic              q_pop;
    logic              init_busy;
    result_t           res;

    assign pready = 1'b1;
    assign hit    = (paddr[2] == 1'b0);
    assign prdata = hit ? mult_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= MULT_RESET;
        end else if (psel && penable && pwrite && hit) begin
            mult_reg <= pwdata;
        end
    end

    lbqs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .init_busy (init_busy),
        .q_pop     (q_pop),
        .q_out     (q_link)
    );

    lbqs_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .index_multiplier (mult_reg),
        .q_in             (q_link),
        .q_pop            (q_pop),
        .init_busy        (init_busy),
        .res_valid        (m_tvalid),
        .res_ready        (m_tready),
        .res              (res)
    );

    assign m_tuser = res.status;
    assign m_tdata = {6'd0, res.max_seen, res.min_seen, res.value_sum,
                      res.total_count, res.bucket_index};

endmodule

// ===== rtl/core/lbqs_checker.sv =====
// port-level checks on the sketch responses, bound to the top level
// depends on lbqs_pkg and log_bucket_quantile_sketch_defines.svh
`timescale 1ns / 1ps
`include "log_bucket_quantile_sketch_defines.svh"

module lbqs_checker
    import lbqs_pkg::*;
(
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [191:0] m_tdata,
    input logic [1:0]   m_tuser
);

    logic [IDX_OUT_W-1:0] idx_f;
    logic [VAL_W-1:0]     min_f, max_f;
    logic                 err_f;

    assign idx_f = m_tdata[10:0];
    assign min_f = m_tdata[153:122];
    assign max_f = m_tdata[185:154];
    assign err_f = (m_tuser != ST_OK);

    `LBQS_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, m_tuser <= ST_EMPTY, "bad status")
    `LBQS_ASSERT_NOW(a_err_index, aclk, aresetn, m_tvalid && err_f, idx_f == '0, "error with index")
    `LBQS_ASSERT_NOW(a_min_max, aclk, aresetn, m_tvalid && max_f != '0, min_f != '0 && min_f <= max_f, "min above max")
    `LBQS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "response dropped")

endmodule

bind log_bucket_quantile_sketch lbqs_checker u_lbqs_checker (.*);
